// ----- sv/sls_pkg.sv -----
// Package for the stairway light sequencer: payload structs, constants, codes.
// No dependencies.
package sls_pkg;

  localparam int MAX_LEDS_DEF = 1024;
  localparam int ERROR_HOLD_MS = 1000;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_RANGE = 2'd0;
  localparam logic [1:0] KIND_EMERG = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_STEP = 3'd2;
  localparam logic [2:0] REG_LEDS = 3'd3;
  localparam logic [2:0] REG_BLOCK = 3'd4;
  localparam logic [2:0] REG_EUP = 3'd5;
  localparam logic [2:0] REG_EDOWN = 3'd6;
  localparam logic [2:0] REG_OPTS = 3'd7;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_FIRST = 3'd1;
  localparam logic [2:0] M_SECOND = 3'd2;
  localparam logic [2:0] M_INC = 3'd3;
  localparam logic [2:0] M_DEC = 3'd4;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        up_first_seen;
    logic        up_second_seen;
    logic        down_first_seen;
    logic        down_second_seen;
    logic [3:0]  sensor_error_mask;
    logic        ambient_bright;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       side;
    logic [9:0] first_index;
    logic [9:0] last_index;
    logic       turn_on;
    logic [7:0] people_now;
    logic       light_blocked;
    logic       error_lamp;
    logic       last;
  } out_item_t;

  // Classified poll handed from the front part to the back part.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  first_seen;
    logic [1:0]  emerg_fire;
    logic        blocked;
    logic [3:0]  wipe_start;
    logic        wipe_forced;
    logic [7:0]  people;
    logic        error_lamp;
  } cmd_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [31:0] inactivity_timeout_ms;
    logic [15:0] step_interval_ms;
    logic [10:0] active_led_count;
    logic [15:0] hold_off_ms;
    logic [10:0] emergency_up_count;
    logic [10:0] emergency_down_count;
    logic [1:0]  option_bits;
  } cfg_t;

endpackage

// ----- sv/sls_front.sv -----
// Front part: detectors, people count, timeout, hold-off and error lamp.
// Depends on sls_pkg; emits one cmd_t per accepted poll.
module sls_front
  import sls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     any_wipe,
  input  logic     q_done,
  input  logic     q_ready,
  output logic     q_valid,
  output cmd_t     q_cmd
);

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

  logic [2:0]  mode [2];
  logic [31:0] dstamp [2];
  logic [7:0]  people;
  logic [31:0] people_stamp;
  logic        blocked;
  logic        last_direction;
  logic [31:0] error_stamp;
  logic        error_lit;
  logic [31:0] hold_stamp [2];
  logic [PEND_W-1:0] pend_wipe;

  logic [2:0]  mode_next [2];
  logic [31:0] dstamp_next [2];
  logic [7:0]  people_next;
  logic [31:0] pstamp_next;
  logic        blocked_next;
  logic        dir_next;
  logic [3:0]  start;
  logic        forced;
  logic        need_idle;
  logic [3:0]  cur;
  logic [1:0]  emerg_fire;
  logic        accept;
  logic [31:0] now;

  // The inactivity check needs the wipe state left by all earlier polls.
  assign in_ready = q_ready && !(need_idle && pend_wipe != '0);
  assign accept = in_valid && in_ready;
  assign now = in_item.now_ms;

  always_comb begin
    logic s1, s2, gt;
    logic [31:0] age;
    logic [7:0] prev;
    cur = {in_item.down_second_seen, in_item.down_first_seen,
           in_item.up_second_seen, in_item.up_first_seen} & ~in_item.sensor_error_mask;
    blocked_next = (in_item.ambient_bright && !cfg.option_bits[0]) ?
                   (blocked || people == 8'd0) : 1'b0;
    people_next = people;
    pstamp_next = people_stamp;
    dir_next = last_direction;
    start = 4'd0;
    forced = 1'b0;
    prev = people;
    for (int d = 0; d < 2; d++) begin
      s1 = cur[2*d];
      s2 = cur[2*d+1];
      age = now - dstamp[d];
      gt = age > {16'd0, cfg.debounce_ms};
      mode_next[d] = mode[d];
      dstamp_next[d] = dstamp[d];
      if (blocked_next) begin
        mode_next[d] = M_IDLE;
        dstamp_next[d] = now;
      end else begin
        unique case (mode[d])
          M_IDLE: begin
            if (s1) begin
              mode_next[d] = M_FIRST; dstamp_next[d] = now;
            end else if (s2) begin
              mode_next[d] = M_SECOND; dstamp_next[d] = now;
            end
          end
          M_FIRST: begin
            if (!s1 && gt) begin
              mode_next[d] = M_IDLE; dstamp_next[d] = now;
            end else if (s2) begin
              mode_next[d] = M_INC; dstamp_next[d] = now;
              if (people_next != 8'd255) people_next = people_next + 8'd1;
              pstamp_next = now;
            end
          end
          M_SECOND: begin
            if (!s2 && gt) begin
              mode_next[d] = M_IDLE; dstamp_next[d] = now;
            end else if (s1) begin
              mode_next[d] = M_DEC; dstamp_next[d] = now;
              if (people_next != 8'd0) begin
                people_next = people_next - 8'd1;
                pstamp_next = now;
              end
            end
          end
          M_INC, M_DEC: begin
            if (!s1 && !s2 && gt) begin
              mode_next[d] = M_IDLE; dstamp_next[d] = now;
            end
          end
          default: ;
        endcase
      end
    end
    // Wipe position checks against N are done by the back part.
    if (prev != people_next) begin
      if (people_next > prev) begin
        if (mode_next[0] == M_INC) begin
          dir_next = 1'b0; start[0] = 1'b1;
        end
        if (mode_next[1] == M_INC) begin
          dir_next = 1'b1; start[2] = 1'b1;
        end
      end else if (people_next == 8'd0) begin
        start[1] = (mode_next[0] == M_DEC);
        start[3] = (mode_next[1] == M_DEC);
      end
    end
    need_idle = people_next != 8'd0 && start == 4'd0 &&
                (now - pstamp_next) > cfg.inactivity_timeout_ms;
    if (need_idle && !any_wipe) begin
      people_next = 8'd0;
      forced = 1'b1;
      if (dir_next) start[1] = 1'b1;
      else start[3] = 1'b1;
    end
    for (int d = 0; d < 2; d++) begin
      emerg_fire[d] = cur[2*d] && !blocked_next && !cfg.option_bits[1] &&
                      (mode_next[d] != M_SECOND) &&
                      (now - hold_stamp[d]) > {16'd0, cfg.hold_off_ms};
    end
  end

  // pend_wipe counts polls accepted and not yet finished by the back part.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < 2; d++) begin
        mode[d] <= M_IDLE;
        dstamp[d] <= '0;
        hold_stamp[d] <= '0;
      end
      people <= '0;
      people_stamp <= '0;
      blocked <= 1'b0;
      last_direction <= 1'b0;
      error_stamp <= '0;
      error_lit <= 1'b0;
      q_valid <= 1'b0;
      pend_wipe <= '0;
    end else begin
      if (q_valid && q_ready && !accept) q_valid <= 1'b0;
      if (accept) begin
        for (int d = 0; d < 2; d++) begin
          mode[d] <= mode_next[d];
          dstamp[d] <= dstamp_next[d];
          if (mode_next[d] == M_SECOND) hold_stamp[d] <= now;
        end
        people <= people_next;
        people_stamp <= pstamp_next;
        blocked <= blocked_next;
        last_direction <= dir_next;
        q_valid <= 1'b1;
        q_cmd.now_ms <= now;
        q_cmd.emerg_fire <= emerg_fire;
        q_cmd.first_seen <= {cur[2], cur[0]};
        q_cmd.blocked <= blocked_next;
        q_cmd.wipe_start <= start;
        q_cmd.wipe_forced <= forced;
        q_cmd.people <= people_next;
        if (in_item.sensor_error_mask != 4'd0) begin
          error_stamp <= now;
          error_lit <= 1'b1;
          q_cmd.error_lamp <= 1'b1;
        end else if ((now - error_stamp) > 32'(ERROR_HOLD_MS)) begin
          error_lit <= 1'b0;
          q_cmd.error_lamp <= 1'b0;
        end else begin
          q_cmd.error_lamp <= error_lit;
        end
      end
      pend_wipe <= pend_wipe + PEND_W'(accept) - PEND_W'(q_done);
    end
  end

endmodule

// ----- sv/sls_queue.sv -----
// Short queue between the front and the back part.
// Depends on sls_pkg for cmd_t.
module sls_queue
  import sls_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  localparam int AW = $clog2(DEPTH);
  cmd_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;
  logic push, pop;

  assign in_ready = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_cmd = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_cmd;
  end

endmodule

// ----- sv/sls_back.sv -----
// Back part: emits emergency, wipe and status items for each queued poll.
// Depends on sls_pkg; at most one item per cycle into an output register, unless stalled.
module sls_back
  import sls_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_cmd,
  output logic      any_wipe,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int PW = $clog2(MAX_LEDS + 1);

  typedef enum logic [1:0] {S_LOAD, S_RUN} state_t;

  state_t      state;
  logic [3:0]  phase;
  logic        stepping;
  logic [31:0] step_stamp;
  logic [3:0]  active;
  logic [PW-1:0] pos [4];
  logic [PW-1:0] nl;
  logic [PW-1:0] end_v;
  logic [PW-1:0] lo_v, hi_v;
  logic        emit;
  logic        fire;
  out_item_t   item;
  logic        slot_free;
  logic [3:0]  act_eff;
  logic [1:0]  w;

  assign slot_free = !out_valid || out_ready;
  assign fire = state == S_RUN && emit && slot_free;
  assign any_wipe = active != 4'd0;
  assign nl = (32'(cfg.active_led_count) > MAX_LEDS) ? PW'(MAX_LEDS)
            : PW'(cfg.active_led_count);
  assign q_ready = state == S_RUN && phase == 4'd8 && slot_free;
  assign w = 2'(phase - 4'd4);

  // Starts are taken only when a wipe's position is not already at N, or when forced.
  always_comb begin
    act_eff = active;
    for (int i = 0; i < 4; i++) begin
      if (q_cmd.wipe_start[i] && (pos[i] != nl || q_cmd.wipe_forced)) act_eff[i] = 1'b1;
    end
  end

  always_comb begin
    logic [31:0] ec;
    emit = 1'b0;
    item = '0;
    end_v = pos[w];
    lo_v = '0;
    hi_v = '0;
    ec = '0;
    if (phase <= 4'd1) begin
      emit = q_cmd.emerg_fire[phase[0]];
      item.kind = KIND_EMERG;
      item.side = phase[0];
      item.turn_on = 1'b1;
    end else if (phase <= 4'd3) begin
      emit = stepping && !q_cmd.first_seen[phase[0]];
      item.kind = KIND_EMERG;
      item.side = phase[0];
    end else if (phase <= 4'd7) begin
      ec = 32'(pos[w]);
      if (!cfg.option_bits[1] && w == 2'd0 && 32'(cfg.emergency_up_count) > ec)
        ec = 32'(cfg.emergency_up_count);
      if (!cfg.option_bits[1] && w == 2'd2 && 32'(cfg.emergency_down_count) > ec)
        ec = 32'(cfg.emergency_down_count);
      if (ec > 32'(nl) - 32'd1) ec = 32'(nl) - 32'd1;
      end_v = PW'(ec);
      if (w == 2'd0 || w == 2'd3) begin
        lo_v = pos[w]; hi_v = end_v;
      end else begin
        lo_v = nl - 1'b1 - end_v; hi_v = nl - 1'b1 - pos[w];
      end
      emit = stepping && active[w] && pos[w] < nl;
      item.kind = KIND_RANGE;
      item.first_index = 10'(lo_v);
      item.last_index = 10'(hi_v);
      item.turn_on = (w == 2'd0 || w == 2'd2);
    end else begin
      emit = 1'b1;
      item.kind = KIND_STATUS;
      item.people_now = q_cmd.people;
      item.light_blocked = q_cmd.blocked;
      item.error_lamp = q_cmd.error_lamp;
      item.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      phase <= '0;
      stepping <= 1'b0;
      step_stamp <= '0;
      active <= '0;
      for (int i = 0; i < 4; i++) pos[i] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        out_item <= item;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            active <= act_eff;
            stepping <= (q_cmd.now_ms - step_stamp) > {16'd0, cfg.step_interval_ms};
            if ((q_cmd.now_ms - step_stamp) > {16'd0, cfg.step_interval_ms})
              step_stamp <= q_cmd.now_ms;
            phase <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!emit || slot_free) begin
            if (phase >= 4'd4 && phase <= 4'd7 && stepping && active[w]) begin
              if (pos[w] >= nl) begin
                pos[w] <= '0;
                active[w] <= 1'b0;
              end else begin
                pos[w] <= end_v + 1'b1;
              end
            end
            if (phase == 4'd8) state <= S_LOAD;
            else phase <= phase + 4'd1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ----- sv/stairway_light_sequencer_core.sv -----
// Top level of the stairway light sequencer: config registers, front, queue, back.
// Depends on sls_pkg, sls_front, sls_queue and sls_back.
//
// Each accepted poll is classified by the front part, registered and queued;
// the back part then handles each poll in one load step and nine result
// slots, writing at most one item per cycle into the output register while
// the output is not stalled. Polls may keep arriving while earlier ones
// drain, except that a poll whose inactivity check is due waits at the input
// until all earlier polls have finished, since that check depends on whether
// a wipe is running.
module stairway_light_sequencer_core
  import sls_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  cfg_t cfg;
  logic fq_valid, fq_ready, qb_valid, qb_ready, any_wipe, q_done;
  cmd_t fq_cmd, qb_cmd;

  assign q_done = qb_valid && qb_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= 16'd200;
      cfg.inactivity_timeout_ms <= 32'd60000;
      cfg.step_interval_ms <= 16'd30;
      cfg.active_led_count <= 11'd16;
      cfg.hold_off_ms <= 16'd2000;
      cfg.emergency_up_count <= '0;
      cfg.emergency_down_count <= '0;
      cfg.option_bits <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ms <= cfg_data[15:0];
        REG_TIMEOUT:  cfg.inactivity_timeout_ms <= cfg_data;
        REG_STEP:     cfg.step_interval_ms <= cfg_data[15:0];
        REG_LEDS:     cfg.active_led_count <= cfg_data[10:0];
        REG_BLOCK:    cfg.hold_off_ms <= cfg_data[15:0];
        REG_EUP:      cfg.emergency_up_count <= cfg_data[10:0];
        REG_EDOWN:    cfg.emergency_down_count <= cfg_data[10:0];
        REG_OPTS:     cfg.option_bits <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  sls_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_ready, .in_item, .any_wipe, .q_done,
    .q_ready(fq_ready), .q_valid(fq_valid), .q_cmd(fq_cmd)
  );

  sls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .in_valid(fq_valid), .in_ready(fq_ready), .in_cmd(fq_cmd),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_cmd(qb_cmd)
  );

  sls_back #(.MAX_LEDS(MAX_LEDS)) u_back (
    .clk, .rst, .cfg, .q_valid(qb_valid), .q_ready(qb_ready), .q_cmd(qb_cmd),
    .any_wipe, .out_valid, .out_ready, .out_item
  );

endmodule

// ----- sv/sls_checker.sv -----
// Port-level checker for the stairway light sequencer, bound to the top level.
// Depends on sls_pkg.
module sls_checker
  import sls_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.kind != 2'd3)
    else $error("undefined result kind");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.last == (out_item.kind == KIND_STATUS))
    else $error("last flag not on status item");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_RANGE |-> out_item.first_index <= out_item.last_index)
    else $error("inverted LED range");

endmodule

bind stairway_light_sequencer_core sls_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .out_item
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for stairway_light_sequencer_core: random and directed sensor polls.
// Carries its own model of the block and compares every result item in order.
// Depends on sls_pkg and the block's RTL.
module testbench;
  import sls_pkg::*;

  localparam int WIPE_ON_UP = 0;
  localparam int WIPE_OFF_UP = 1;
  localparam int WIPE_ON_DOWN = 2;
  localparam int WIPE_OFF_DOWN = 3;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_DEBOUNCE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  stairway_light_sequencer_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model registers and state.
  logic [15:0] debounce_r = 16'd200;
  logic [31:0] timeout_r = 32'd60000;
  logic [15:0] step_r = 16'd30;
  logic [10:0] leds_r = 11'd16;
  logic [15:0] block_r = 16'd2000;
  logic [10:0] eup_r = 11'd0;
  logic [10:0] edown_r = 11'd0;
  logic [1:0] opts_r = 2'd0;

  logic [2:0] det_mode [2];
  logic [31:0] det_stamp [2];
  logic [31:0] people_cnt, prev_people, people_stamp;
  logic blocked_flag, last_dir;
  logic wipe_on [4];
  logic [31:0] wipe_pos [4];
  logic [31:0] step_stamp, err_stamp;
  logic [31:0] hold_stamp [2];
  logic err_lit;

  out_item_t expected_results[$];
  in_item_t pending_polls[$];
  logic [31:0] clock_ms;
  int polls_sent, polls_taken, results_taken, results_seen;
  int gap_left, stall_left, cycles;
  bit burst_in, burst_out, failed;

  initial begin
    for (int i = 0; i < 2; i++) begin
      det_mode[i] = M_IDLE;
      det_stamp[i] = '0;
      hold_stamp[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      wipe_on[i] = 1'b0;
      wipe_pos[i] = '0;
    end
    people_cnt = '0; prev_people = '0; people_stamp = '0;
    blocked_flag = 1'b0; last_dir = 1'b0;
    step_stamp = '0; err_stamp = '0; err_lit = 1'b0;
  end

  function automatic void add_result(logic [1:0] kind, logic side, logic [31:0] lo,
                                     logic [31:0] hi, logic on);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.side = side;
    r.first_index = lo[9:0];
    r.last_index = hi[9:0];
    r.turn_on = on;
    expected_results.push_back(r);
  endfunction

  function automatic void advance_detector(int d, logic s1, logic s2, logic [31:0] now);
    logic [31:0] age;
    age = now - det_stamp[d];
    case (det_mode[d])
      M_IDLE: begin
        if (s1) begin
          det_mode[d] = M_FIRST; det_stamp[d] = now;
        end else if (s2) begin
          det_mode[d] = M_SECOND; det_stamp[d] = now;
        end
      end
      M_FIRST: begin
        if (!s1 && age > debounce_r) begin
          det_mode[d] = M_IDLE; det_stamp[d] = now;
        end else if (s2) begin
          det_mode[d] = M_INC; det_stamp[d] = now;
          if (people_cnt < 255) people_cnt = people_cnt + 1;
          people_stamp = now;
        end
      end
      M_SECOND: begin
        if (!s2 && age > debounce_r) begin
          det_mode[d] = M_IDLE; det_stamp[d] = now;
        end else if (s1) begin
          det_mode[d] = M_DEC; det_stamp[d] = now;
          if (people_cnt != 0) begin
            people_cnt = people_cnt - 1; people_stamp = now;
          end
        end
      end
      M_INC, M_DEC: begin
        if (!s1 && !s2 && age > debounce_r) begin
          det_mode[d] = M_IDLE; det_stamp[d] = now;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_poll(in_item_t p);
    logic [31:0] now, nl, pos, stop, diff;
    logic [3:0] seen;
    logic emerg;
    out_item_t st;
    now = p.now_ms;
    seen = {p.down_second_seen, p.down_first_seen, p.up_second_seen, p.up_first_seen}
           & ~p.sensor_error_mask;
    emerg = !opts_r[1];
    nl = (leds_r > 11'd1024) ? 32'd1024 : 32'(leds_r);

    if (p.ambient_bright && !opts_r[0]) begin
      if (people_cnt == 0) blocked_flag = 1'b1;
    end else begin
      blocked_flag = 1'b0;
    end
    for (int d = 0; d < 2; d++) begin
      if (blocked_flag) begin
        det_mode[d] = M_IDLE; det_stamp[d] = now;
      end else begin
        advance_detector(d, seen[2*d], seen[2*d+1], now);
      end
    end

    if (prev_people != people_cnt) begin
      if (people_cnt > prev_people) begin
        if (det_mode[0] == M_INC) begin
          last_dir = 1'b0;
          if (wipe_pos[WIPE_ON_UP] != nl) wipe_on[WIPE_ON_UP] = 1'b1;
        end
        if (det_mode[1] == M_INC) begin
          last_dir = 1'b1;
          if (wipe_pos[WIPE_ON_DOWN] != nl) wipe_on[WIPE_ON_DOWN] = 1'b1;
        end
      end else if (people_cnt == 0) begin
        if (det_mode[0] == M_DEC && wipe_pos[WIPE_OFF_UP] != nl) wipe_on[WIPE_OFF_UP] = 1'b1;
        if (det_mode[1] == M_DEC && wipe_pos[WIPE_OFF_DOWN] != nl)
          wipe_on[WIPE_OFF_DOWN] = 1'b1;
      end
      prev_people = people_cnt;
    end

    diff = now - people_stamp;
    if (people_cnt > 0 && !wipe_on[0] && !wipe_on[1] && !wipe_on[2] && !wipe_on[3] &&
        diff > timeout_r) begin
      people_cnt = 0; prev_people = 0;
      if (last_dir == 1'b0) wipe_on[WIPE_OFF_DOWN] = 1'b1;
      else wipe_on[WIPE_OFF_UP] = 1'b1;
    end

    for (int d = 0; d < 2; d++)
      if (det_mode[d] == M_SECOND) hold_stamp[d] = now;
    for (int d = 0; d < 2; d++) begin
      diff = now - hold_stamp[d];
      if (seen[2*d] && !blocked_flag && emerg && diff > block_r)
        add_result(KIND_EMERG, d[0], 0, 0, 1'b1);
    end

    diff = now - step_stamp;
    if (diff > step_r) begin
      step_stamp = now;
      for (int d = 0; d < 2; d++)
        if (!seen[2*d]) add_result(KIND_EMERG, d[0], 0, 0, 1'b0);
      for (int w = 0; w < 4; w++) begin
        if (wipe_on[w]) begin
          pos = wipe_pos[w];
          stop = pos;
          if (pos >= nl) begin
            wipe_pos[w] = 0; wipe_on[w] = 1'b0;
          end else begin
            if (emerg && w == WIPE_ON_UP && eup_r > stop) stop = 32'(eup_r);
            if (emerg && w == WIPE_ON_DOWN && edown_r > stop) stop = 32'(edown_r);
            if (stop > nl - 1) stop = nl - 1;
            if (w == WIPE_ON_UP || w == WIPE_OFF_DOWN)
              add_result(KIND_RANGE, 1'b0, pos, stop, w == WIPE_ON_UP);
            else
              add_result(KIND_RANGE, 1'b0, nl - 1 - stop, nl - 1 - pos, w == WIPE_ON_DOWN);
            wipe_pos[w] = stop + 1;
          end
        end
      end
    end

    diff = now - err_stamp;
    if (p.sensor_error_mask != 0) begin
      err_stamp = now; err_lit = 1'b1;
    end else if (diff > ERROR_HOLD_MS) begin
      err_lit = 1'b0;
    end

    st = '0;
    st.kind = KIND_STATUS;
    st.people_now = people_cnt[7:0];
    st.light_blocked = blocked_flag;
    st.error_lamp = err_lit;
    st.last = 1'b1;
    expected_results.push_back(st);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Sampling side: predicts accepted polls and checks accepted results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) begin
      predict_poll(in_item);
      polls_taken <= polls_taken + 1;
    end
    if (!rst && out_valid && out_ready) begin
      results_taken <= results_taken + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        failed = 1'b1;
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_item.kind));
        check_field("side", 32'(want.side), 32'(out_item.side));
        check_field("first_index", 32'(want.first_index), 32'(out_item.first_index));
        check_field("last_index", 32'(want.last_index), 32'(out_item.last_index));
        check_field("turn_on", 32'(want.turn_on), 32'(out_item.turn_on));
        check_field("people_now", 32'(want.people_now), 32'(out_item.people_now));
        check_field("light_blocked", 32'(want.light_blocked), 32'(out_item.light_blocked));
        check_field("error_lamp", 32'(want.error_lamp), 32'(out_item.error_lamp));
        check_field("last", 32'(want.last), 32'(out_item.last));
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Poll driver.
  always @(negedge clk) begin
    if (!rst && !(in_valid && polls_sent != polls_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_polls.size() > 0) begin
        in_item <= pending_polls.pop_front();
        in_valid <= 1'b1;
        polls_sent <= polls_sent + 1;
        gap_left <= burst_in ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls.
  always @(negedge clk) begin : receiver
    int draw;
    if (!rst) begin
      if (results_seen != results_taken) begin
        results_seen <= results_taken;
        draw = burst_out ? 0 : $urandom_range(0, 5);
        stall_left <= (draw == 0) ? 0 : draw - 1;
        out_ready <= (draw == 0);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_poll(logic [31:0] dt, logic [3:0] s, logic [3:0] errs, logic bright);
    in_item_t p;
    clock_ms = clock_ms + dt;
    p.now_ms = clock_ms;
    {p.down_second_seen, p.down_first_seen, p.up_second_seen, p.up_first_seen} = s;
    p.sensor_error_mask = errs;
    p.ambient_bright = bright;
    pending_polls.push_back(p);
  endtask

  // One person passing a detector, forward or in reverse.
  task automatic walk(int d, bit reverse);
    logic [3:0] a, b, errs;
    logic bright;
    a = reverse ? (4'b0010 << (2*d)) : (4'b0001 << (2*d));
    b = reverse ? (4'b0001 << (2*d)) : (4'b0010 << (2*d));
    errs = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    bright = ($urandom_range(0, 7) == 0);
    push_poll($urandom_range(1, 150), a, errs, bright);
    push_poll($urandom_range(1, 150), a | b, 4'd0, bright);
    if ($urandom_range(0, 5) != 0) push_poll($urandom_range(1, 150), b, 4'd0, bright);
    push_poll($urandom_range(1, 400), 4'd0, 4'd0, bright);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_DEBOUNCE: debounce_r = value[15:0];
      REG_TIMEOUT: timeout_r = value;
      REG_STEP: step_r = value[15:0];
      REG_LEDS: leds_r = value[10:0];
      REG_BLOCK: block_r = value[15:0];
      REG_EUP: eup_r = value[10:0];
      REG_EDOWN: edown_r = value[10:0];
      default: opts_r = value[1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [15:0] deb, logic [31:0] tmo, logic [15:0] stp,
                           logic [10:0] leds, logic [15:0] blk, logic [10:0] eu,
                           logic [10:0] ed, logic [1:0] opts);
    write_reg(REG_DEBOUNCE, 32'(deb));
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_STEP, 32'(stp));
    write_reg(REG_LEDS, 32'(leds));
    write_reg(REG_BLOCK, 32'(blk));
    write_reg(REG_EUP, 32'(eu));
    write_reg(REG_EDOWN, 32'(ed));
    write_reg(REG_OPTS, 32'(opts));
  endtask

  task automatic drain();
    while (pending_polls.size() != 0 || polls_sent != polls_taken ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [10:0] leds;
    failed = 1'b0;
    cycles = 0; polls_sent = 0; polls_taken = 0; results_taken = 0; results_seen = 0;
    gap_left = 0; stall_left = 0; burst_in = 1'b0; burst_out = 1'b0;
    clock_ms = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed polls at the reset settings.
    push_poll(0, 4'd0, 4'd0, 1'b0);
    push_poll(50, 4'b0001, 4'd0, 1'b0);
    push_poll(50, 4'b0011, 4'd0, 1'b0);
    push_poll(50, 4'b0010, 4'd0, 1'b0);
    push_poll(300, 4'd0, 4'd0, 1'b0);
    for (int i = 0; i < 6; i++) push_poll(31, 4'd0, 4'd0, 1'b0);
    push_poll(40, 4'b1000, 4'd0, 1'b0);
    push_poll(40, 4'b1100, 4'd0, 1'b0);
    push_poll(3000, 4'b0001, 4'd0, 1'b1);
    push_poll(70000, 4'b1111, 4'b1111, 1'b1);
    push_poll(10, 4'd0, 4'b0001, 1'b0);
    push_poll(10, 4'd0, 4'b0010, 1'b0);
    push_poll(10, 4'd0, 4'b0100, 1'b0);
    push_poll(10, 4'd0, 4'b1000, 1'b0);
    push_poll(1500, 4'd0, 4'd0, 1'b1);
    push_poll(32'hFFFF_FFFF - clock_ms, 4'b0101, 4'd0, 1'b0);
    push_poll(5, 4'd0, 4'd0, 1'b0);
    drain();

    // Extremes of every register.
    configure(16'd0, 32'd500, 16'd0, 11'd1, 16'd0, 11'd1024, 11'd1024, 2'd0);
    for (int i = 0; i < 4; i++) walk(i % 2, 1'b0);
    push_poll(600, 4'd0, 4'd0, 1'b0);
    drain();
    configure(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 11'd1024, 16'hFFFF, 11'd0, 11'd0, 2'd3);
    for (int i = 0; i < 3; i++) walk(i % 2, i == 2);
    push_poll(32'h0001_0000, 4'd0, 4'd0, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 6))
        0: leds = 11'd0;
        1: leds = 11'h7FF;
        2: leds = 11'd1024;
        default: leds = 11'($urandom_range(1, 24));
      endcase
      burst_in = (ph == 2);
      burst_out = (ph == 3);
      configure(16'($urandom_range(0, 300)),
                ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1000)) : 32'd4000,
                16'($urandom_range(0, 60)), leds, 16'($urandom_range(0, 1500)),
                11'($urandom_range(0, 30)),
                ($urandom_range(0, 4) == 0) ? 11'h7FF : 11'($urandom_range(0, 30)),
                2'($urandom_range(0, 3)));
      for (int k = 0; k < 9; k++) begin
        if ($urandom_range(0, 5) == 0)
          push_poll(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 5000),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)));
        else
          walk($urandom_range(0, 1), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0)
          for (int j = 0; j < 2; j++) push_poll($urandom_range(20, 200), 4'd0, 4'd0, 1'b0);
      end
      drain();
    end

    if (!failed && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived, expected %p, actual none",
                 $time, expected_results.size(), expected_results[0]);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sls_pkg.sv
sv/sls_front.sv
sv/sls_queue.sv
sv/sls_back.sv
sv/stairway_light_sequencer_core.sv
sv/sls_checker.sv
tb/sv/testbench.sv
